>>> src/teach_playback_sequencer_assert.svh
// Assertion macros shared by the sequencer RTL. They compile to nothing in synthesis.
`ifndef TEACH_PLAYBACK_SEQUENCER_ASSERT_SVH
`define TEACH_PLAYBACK_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define TPS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");
`define TPS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");
`else
`define TPS_ASSERT_IMP(name, ante, cons)
`define TPS_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> src/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

    typedef enum logic [1:0] {
        MODE_PROG = 2'd0,
        MODE_TEST = 2'd1,
        MODE_RUN  = 2'd2,
        MODE_STOP = 2'd3
    } mode_t;

    localparam int unsigned NUM_BTN   = 5;
    localparam int unsigned BTN_STOP  = 0;
    localparam int unsigned BTN_RUN   = 1;
    localparam int unsigned BTN_RESET = 2;
    localparam int unsigned BTN_SET   = 3;
    localparam int unsigned BTN_TEST  = 4;

    localparam logic [15:0] STEP_PERIOD_RESET = 16'd2000;

    // 90/255 reduces to 6/17; 3856/65536 approximates 1/17 closely enough to floor
    // exactly for every product up to 6*255.
    localparam logic [10:0] SCALE_MUL = 11'd6;
    localparam logic [22:0] RECIP_17  = 23'd3856;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic load_scaled;
    } tps_act_t;

    function automatic logic [6:0] scale_encoder(input logic [7:0] raw);
        logic [10:0] x;
        logic [22:0] p;
        x = 11'(raw) * SCALE_MUL;
        p = 23'(x) * RECIP_17;
        return p[22:16];
    endfunction

endpackage

>>> src/tps_ram.sv
`timescale 1ns / 1ps

module tps_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/tps_ctrl.sv
`timescale 1ns / 1ps

module tps_ctrl import tps_pkg::*; #(
    parameter int SEQ_DEPTH = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic [NUM_BTN-1:0] btn,
    input  logic [15:0]        step_period,
    output mode_t              mode_reg,
    output logic [IDX_W-1:0]   index_reg,
    output logic [CNT_W-1:0]   length_reg,
    output tps_act_t           act,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [IDX_W-1:0]   rd_addr
);

    mode_t              mode_next;
    logic [IDX_W-1:0]   index_next;
    logic [CNT_W-1:0]   length_next;
    logic [15:0]        tick_reg;
    logic [15:0]        tick_next;
    logic [15:0]        tick_inc;
    logic [NUM_BTN-1:0] prev_reg;
    logic [NUM_BTN-1:0] rise;
    logic [CNT_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   idx_last;
    logic               seq_empty;

    assign rise      = btn & ~prev_reg;
    assign tick_inc  = tick_reg + 16'd1;
    assign idx_inc   = CNT_W'(index_reg) + CNT_W'(1);
    assign seq_empty = (length_reg == '0);
    assign idx_last  = seq_empty ? '0 : IDX_W'(length_reg - CNT_W'(1));
    assign wr_addr   = length_reg[IDX_W-1:0];
    assign rd_addr   = index_next;

    always_comb begin
        mode_next   = mode_reg;
        index_next  = index_reg;
        length_next = length_reg;
        tick_next   = tick_reg;
        act         = '0;
        priority if (rise[BTN_RESET]) begin
            mode_next   = MODE_PROG;
            length_next = '0;
            index_next  = '0;
            tick_next   = '0;
        end else if (rise[BTN_STOP]) begin
            mode_next = MODE_STOP;
        end else if (rise[BTN_RUN] && !seq_empty) begin
            mode_next = MODE_RUN;
            tick_next = '0;
        end else if (rise[BTN_TEST] && !seq_empty) begin
            mode_next  = MODE_TEST;
            index_next = '0;
            tick_next  = '0;
        end else begin
            unique case (mode_reg)
                MODE_PROG: begin
                    act.load_scaled = 1'b1;
                    if (rise[BTN_SET] && (length_reg < CNT_W'(SEQ_DEPTH))) begin
                        act.wr_en   = 1'b1;
                        length_next = length_reg + CNT_W'(1);
                    end
                end
                MODE_TEST, MODE_RUN: begin
                    act.rd_en = 1'b1;
                    if (tick_inc >= step_period) begin
                        tick_next = '0;
                        if (idx_inc >= length_reg) begin
                            // Test playback holds on the last entry, run playback wraps.
                            index_next = (mode_reg == MODE_TEST) ? idx_last : '0;
                        end else begin
                            index_next = idx_inc[IDX_W-1:0];
                        end
                    end else begin
                        tick_next = tick_inc;
                    end
                end
                MODE_STOP: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_PROG;
            index_reg  <= '0;
            length_reg <= '0;
            tick_reg   <= '0;
            prev_reg   <= '0;
        end else if (adv) begin
            mode_reg   <= mode_next;
            index_reg  <= index_next;
            length_reg <= length_next;
            tick_reg   <= tick_next;
            prev_reg   <= btn;
        end
    end

endmodule

>>> src/teach_playback_sequencer.sv
`timescale 1ns / 1ps
// Teach-and-playback sequencer, one input beat per millisecond tick.
// The s_ channel carries five button levels and the raw encoder reading; the
// m_ channel returns one result beat per tick: mode, playback index, number of
// stored entries and the shown value (0..90). Both channels are valid/ready.
// step_period is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce. An accepted
// s_ beat passes the input register, then the control logic into the state/result
// registers and the registered read of the sequence store, which form its m_ beat.
// Throughput is one beat per cycle; the input register and the result
// register form a two-stage pipeline that moves whenever the result slot is
// free or being emptied.
// When the receiver stalls, the result beat holds and one further s_ beat is
// taken into the input register before s_ready falls.
// After reset the block is in programming mode with an empty sequence, the
// shown value is zero and step_period is 2000. The store needs no clearing:
// only entries below the stored count are ever read.
module teach_playback_sequencer import tps_pkg::*; #(
    parameter int SEQ_DEPTH = 16
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              s_valid,
    output logic                                              s_ready,
    input  logic                                              s_stop_btn,
    input  logic                                              s_run_btn,
    input  logic                                              s_reset_btn,
    input  logic                                              s_set_btn,
    input  logic                                              s_test_btn,
    input  logic [7:0]                                        s_encoder_value,
    output logic                                              m_valid,
    input  logic                                              m_ready,
    output logic [1:0]                                        m_mode,
    output logic [((SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1)-1:0] m_step_index,
    output logic [$clog2(SEQ_DEPTH + 1)-1:0]                  m_step_count,
    output logic [6:0]                                        m_shown_value,
    input  logic                                              cfg_wr_en,
    input  logic [15:0]                                       cfg_wr_data
);

`include "teach_playback_sequencer_assert.svh"

    localparam int IDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(SEQ_DEPTH + 1);

    logic [15:0]        step_period_reg;
    logic               in_valid_reg;
    logic [NUM_BTN-1:0] btn_reg;
    logic [7:0]         enc_reg;
    logic               out_valid_reg;
    logic               adv;
    logic [6:0]         scaled;
    logic [6:0]         value_reg;
    logic [6:0]         value_next;
    logic               vsrc_reg;
    logic               vsrc_next;
    logic [6:0]         ram_rdata;
    mode_t              mode_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [CNT_W-1:0]   length_reg;
    tps_act_t           act;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;

    // The pipeline moves when the input register holds a beat and the result slot is empty or its beat is being taken.
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign scaled  = scale_encoder(enc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg <= STEP_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            step_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            btn_reg <= {s_test_btn, s_set_btn, s_reset_btn, s_run_btn, s_stop_btn};
            enc_reg <= s_encoder_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    tps_ctrl #(
        .SEQ_DEPTH (SEQ_DEPTH),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .btn         (btn_reg),
        .step_period (step_period_reg),
        .mode_reg    (mode_reg),
        .index_reg   (index_reg),
        .length_reg  (length_reg),
        .act         (act),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr)
    );

    tps_ram #(
        .WIDTH (7),
        .DEPTH (SEQ_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (adv && act.wr_en),
        .waddr (wr_addr),
        .wdata (scaled),
        .re    (adv && act.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // The shown value lives either in value_reg or, after a playback read, in the
    // store's read register, which holds until the next read.
    always_comb begin
        value_next = value_reg;
        vsrc_next  = vsrc_reg;
        if (act.load_scaled) begin
            value_next = scaled;
            vsrc_next  = 1'b0;
        end else if (act.rd_en) begin
            vsrc_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            vsrc_reg  <= 1'b0;
        end else if (adv) begin
            value_reg <= value_next;
            vsrc_reg  <= vsrc_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_mode        = mode_reg;
    assign m_step_index  = index_reg;
    assign m_step_count  = length_reg;
    assign m_shown_value = vsrc_reg ? ram_rdata : value_reg;

    `TPS_ASSERT_IMP(a_index_in_seq, (mode_reg == MODE_TEST) || (mode_reg == MODE_RUN), CNT_W'(index_reg) < length_reg)
    `TPS_ASSERT_IMP(a_count_bound, 1'b1, length_reg <= CNT_W'(SEQ_DEPTH))
    `TPS_ASSERT_NXT(a_adv_gives_beat, adv, m_valid)
    `TPS_ASSERT_IMP(a_one_store_port, adv, !(act.wr_en && act.rd_en))

endmodule

>>> tb/sv/teach_playback_sequencer_test.sv
`timescale 1ns / 1ps

module teach_playback_sequencer_test import tps_pkg::*;;

    localparam int DEPTH       = 16;
    localparam int IDLE_PCT    = 21;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_TICKS = 700;
    localparam int PHASE_TICKS = 90;
    localparam int SHOWN_TOP   = 90;
    localparam int ENC_FULL    = 255;

    typedef struct packed {
        logic       stop_btn;
        logic       run_btn;
        logic       reset_btn;
        logic       set_btn;
        logic       test_btn;
        logic [7:0] encoder_value;
    } tick_t;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] step_index;
        logic [4:0] step_count;
        logic [6:0] shown_value;
    } panel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tick_t       cur_tick = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_mode;
    logic [3:0]  m_step_index;
    logic [4:0]  m_step_count;
    logic [6:0]  m_shown_value;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // Pending ticks for the driver and the panels they should produce.
    tick_t  tick_q[$];
    panel_t panel_q[$];
    int     issued = 0;
    int     accepted = 0;
    int     queued = 0;
    int     mismatches = 0;
    int     stall_cycles = 0;
    int     cycle_cnt = 0;
    logic   quiet;

    // Shadow state of the sequencer.
    logic [15:0] period_setting = STEP_PERIOD_RESET;
    mode_t       cur_mode = MODE_PROG;
    logic [15:0] tick_cnt = '0;
    int          play_idx = 0;
    int          seq_len = 0;
    logic [6:0]  shown = '0;
    logic [4:0]  prev_lvl = '0;
    logic [6:0]  taught[DEPTH];

    teach_playback_sequencer #(
        .SEQ_DEPTH(DEPTH)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_stop_btn     (cur_tick.stop_btn),
        .s_run_btn      (cur_tick.run_btn),
        .s_reset_btn    (cur_tick.reset_btn),
        .s_set_btn      (cur_tick.set_btn),
        .s_test_btn     (cur_tick.test_btn),
        .s_encoder_value(cur_tick.encoder_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode         (m_mode),
        .m_step_index   (m_step_index),
        .m_step_count   (m_step_count),
        .m_shown_value  (m_shown_value),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Both sides run without idling while quiet is high, the first fifth of each cycle_cnt period.
    assign quiet = (cycle_cnt % 1000) < 200;

    function automatic logic period_elapsed();
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= period_setting) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic advance_panel(input tick_t t);
        logic [4:0] now_lvl;
        logic [4:0] rise;
        panel_t     p;
        now_lvl = '0;
        now_lvl[BTN_STOP]  = t.stop_btn;
        now_lvl[BTN_RUN]   = t.run_btn;
        now_lvl[BTN_RESET] = t.reset_btn;
        now_lvl[BTN_SET]   = t.set_btn;
        now_lvl[BTN_TEST]  = t.test_btn;
        rise = now_lvl & ~prev_lvl;
        if (rise[BTN_RESET]) begin
            cur_mode = MODE_PROG;
            seq_len  = 0;
            play_idx = 0;
            tick_cnt = '0;
        end else if (rise[BTN_STOP]) begin
            cur_mode = MODE_STOP;
        end else if (rise[BTN_RUN] && seq_len != 0) begin
            cur_mode = MODE_RUN;
            tick_cnt = '0;
        end else if (rise[BTN_TEST] && seq_len != 0) begin
            cur_mode = MODE_TEST;
            play_idx = 0;
            tick_cnt = '0;
        end else begin
            case (cur_mode)
                MODE_PROG: begin
                    shown = 7'((int'(t.encoder_value) * SHOWN_TOP) / ENC_FULL);
                    if (rise[BTN_SET] && seq_len < DEPTH) begin
                        taught[seq_len] = shown;
                        seq_len++;
                    end
                end
                MODE_TEST: begin
                    // A single pass: the last entry is held once reached.
                    if (period_elapsed()) begin
                        play_idx = (play_idx + 1 >= seq_len) ? seq_len - 1 : play_idx + 1;
                    end
                    shown = taught[play_idx];
                end
                MODE_RUN: begin
                    if (period_elapsed()) begin
                        play_idx = (play_idx + 1 >= seq_len) ? 0 : play_idx + 1;
                    end
                    shown = taught[play_idx];
                end
                default: begin
                end
            endcase
        end
        prev_lvl = now_lvl;
        p.mode        = cur_mode;
        p.step_index  = 4'(play_idx);
        p.step_count  = 5'(seq_len);
        p.shown_value = shown;
        panel_q.push_back(p);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_panel(cur_tick);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tick_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_tick <= tick_q.pop_front();
                    issued++;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        panel_t want;
        cycle_cnt <= cycle_cnt + 1;
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (panel_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end else begin
                want = panel_q.pop_front();
                if (m_mode !== want.mode) begin
                    $error("mode: expected %0d, got %0d", want.mode, m_mode);
                    mismatches++;
                end
                if (m_step_index !== want.step_index) begin
                    $error("step_index: expected %0d, got %0d", want.step_index, m_step_index);
                    mismatches++;
                end
                if (m_step_count !== want.step_count) begin
                    $error("step_count: expected %0d, got %0d", want.step_count, m_step_count);
                    mismatches++;
                end
                if (m_shown_value !== want.shown_value) begin
                    $error("shown_value: expected %0d, got %0d", want.shown_value,
                           m_shown_value);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_tick(input logic [4:0] lvl, input logic [7:0] enc);
        tick_t t;
        t.stop_btn      = lvl[BTN_STOP];
        t.run_btn       = lvl[BTN_RUN];
        t.reset_btn     = lvl[BTN_RESET];
        t.set_btn       = lvl[BTN_SET];
        t.test_btn      = lvl[BTN_TEST];
        t.encoder_value = enc;
        tick_q.push_back(t);
        queued++;
    endtask

    // One press is a beat with the button down followed by one with it released.
    task automatic press(input int unsigned btn, input logic [7:0] enc);
        logic [4:0] lvl;
        lvl = '0;
        lvl[btn] = 1'b1;
        push_tick(lvl, enc);
        push_tick('0, enc);
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || issued != accepted || panel_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_period(input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        period_setting = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Teach a short sequence, play it back, and now and then pause and resume.
    task automatic queue_playback();
        int         n;
        logic [7:0] enc;
        if ($urandom_range(0, 3) != 0) begin
            press(BTN_RESET, 8'($urandom));
        end
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5);
        repeat (n) begin
            enc = 8'($urandom);
            push_tick('0, enc);
            press(BTN_SET, enc);
        end
        press($urandom_range(0, 1) ? BTN_RUN : BTN_TEST, 8'($urandom));
        repeat ($urandom_range(2, 30)) push_tick('0, 8'($urandom));
        if ($urandom_range(0, 1)) begin
            press(BTN_STOP, 8'($urandom));
            repeat (3) push_tick('0, 8'($urandom));
            press($urandom_range(0, 1) ? BTN_RUN : BTN_TEST, 8'($urandom));
            repeat ($urandom_range(2, 12)) push_tick('0, 8'($urandom));
        end
    endtask

    task automatic queue_noise();
        logic [4:0] lvl;
        repeat ($urandom_range(4, 20)) begin
            lvl = 5'($urandom);
            if ($urandom_range(0, 2) != 0) begin
                lvl = lvl & 5'($urandom);
            end
            push_tick(lvl, 8'($urandom));
        end
    endtask

    initial begin
        int         phase;
        int         phase_start;
        logic [15:0] period;
        logic [4:0] all_btn;
        logic [4:0] stop_run;
        all_btn = '1;
        stop_run = '0;
        stop_run[BTN_STOP] = 1'b1;
        stop_run[BTN_RUN]  = 1'b1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset period: scaling extremes, edges on an empty
        // sequence, a set outside programming mode and simultaneous presses.
        push_tick('0, 8'd0);
        push_tick('0, 8'd255);
        press(BTN_RUN, 8'd40);
        press(BTN_TEST, 8'd40);
        press(BTN_SET, 8'd255);
        press(BTN_SET, 8'd0);
        press(BTN_SET, 8'd170);
        press(BTN_TEST, 8'd1);
        press(BTN_SET, 8'd9);
        press(BTN_STOP, 8'd2);
        press(BTN_RUN, 8'd3);
        push_tick(all_btn, 8'd85);
        push_tick('0, 8'd85);
        push_tick(stop_run, 8'd128);
        push_tick('0, 8'd127);
        wait_drained();

        phase = 0;
        queued = 0;
        while (queued < RANDOM_TICKS) begin
            case (phase)
                0: period = 16'd1;
                1: period = 16'd65535;
                2: period = 16'd2;
                3: period = 16'd1;
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        period = 16'($urandom_range(9, 65535));
                    end else begin
                        period = 16'($urandom_range(1, 6));
                    end
                end
            endcase
            write_period(period);
            phase_start = queued;
            while (queued - phase_start < PHASE_TICKS) begin
                if ($urandom_range(0, 9) < 7) begin
                    queue_playback();
                end else begin
                    queue_noise();
                end
            end
            wait_drained();
            phase++;
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("status: fail");
        $finish;
    end

endmodule
